// ===== rtl/core/hpq_pkg.sv =====
package hpq_pkg;

    localparam int CAPACITY = 64;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int CH_W     = IDX_W + 2;
    localparam int ENT_W    = 64;

    typedef struct packed {
        logic signed [31:0] pri;
        logic signed [31:0] val;
    } t_entry;

    typedef enum logic [1:0] {
        ACT_INSERT  = 2'd0,
        ACT_EXTRACT = 2'd1,
        ACT_MODIFY  = 2'd2,
        ACT_NONE    = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_FULL    = 2'd2,
        ST_MISSING = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EX_ROOT,
        S_EX_LAST,
        S_SC_RD,
        S_SC_CHK,
        S_UP_RD,
        S_UP_CMP,
        S_DN_RDL,
        S_DN_RDR,
        S_DN_CMP,
        S_FIN_RD,
        S_FIN_WT
    } t_state;

    typedef struct packed {
        logic lt;
        logic pri_eq;
        logic val_eq;
    } t_cmp_res;

endpackage

// ===== rtl/core/hpq_ram.sv =====
module hpq_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 64,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/hpq_cmp.sv =====
module hpq_cmp import hpq_pkg::*; (
    input  logic signed [31:0] i_pri_a,
    input  logic signed [31:0] i_pri_b,
    input  logic signed [31:0] i_val_a,
    input  logic signed [31:0] i_val_b,
    output t_cmp_res           o_res
);

    always_comb begin
        o_res.lt     = i_pri_a < i_pri_b;
        o_res.pri_eq = i_pri_a == i_pri_b;
        o_res.val_eq = i_val_a == i_val_b;
    end

endmodule

// ===== rtl/core/binary_max_heap_priority_queue.sv =====
// insert: the new entry starts at the end and climbs toward the root, moving smaller parents down
// extract: reads the root, then the last entry, and sinks the last entry from the root
// modify: scans entries for a matching value, then climbs or sinks that entry as above;
// status is missing when no value matches. one item at a time: the single heap memory read
// port and one shared priority comparator set the pace
// synchronous active-low reset empties the queue; heap memory is not cleared
module binary_max_heap_priority_queue import hpq_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // action[1:0], item_value[33:2], item_priority[65:34], zero pad
    input  logic [71:0]  i_s_tdata,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // status[1:0], out_value[33:2], out_priority[65:34], entry_count[72:66],
    // top_valid[73], top_value[105:74], top_priority[137:106], zero pad
    output logic [143:0] o_m_tdata
);

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [IDX_W-1:0]   r_idx, n_idx;
    logic [CNT_W-1:0]   r_scan, n_scan;
    t_entry             r_cur, n_cur;
    t_entry             r_best, n_best;
    logic [IDX_W-1:0]   r_best_idx, n_best_idx;
    logic signed [31:0] r_val, n_val;
    logic signed [31:0] r_pri, n_pri;
    t_status            r_status, n_status;
    logic signed [31:0] r_ov, n_ov;
    logic signed [31:0] r_op, n_op;
    logic               r_m_valid;
    logic [143:0]       r_m_data;

    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr, ram_raddr;
    t_entry             ram_wdata, rd;
    logic [ENT_W-1:0]   rd_bits;

    logic signed [31:0] cmp_a, cmp_b;
    t_cmp_res           cmp;

    logic [CH_W-1:0]    child_l, child_r, count_x;
    logic [IDX_W-1:0]   parent;
    t_entry             dec_e;
    logic [IDX_W-1:0]   dec_i;
    logic               load_out;
    t_entry             top_e;

    hpq_ram #(.DEPTH(CAPACITY), .WIDTH(ENT_W), .AW(IDX_W)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (rd_bits)
    );

    assign rd = t_entry'(rd_bits);

    hpq_cmp u_cmp (
        .i_pri_a (cmp_a),
        .i_pri_b (cmp_b),
        .i_val_a (rd.val),
        .i_val_b (r_val),
        .o_res   (cmp)
    );

    assign child_l  = ({{(CH_W-IDX_W){1'b0}}, r_idx} << 1) + CH_W'(1);
    assign child_r  = child_l + CH_W'(1);
    assign count_x  = CH_W'(r_count);
    assign parent   = (r_idx - IDX_W'(1)) >> 1;
    assign load_out = (r_state == S_FIN_WT) && (!r_m_valid || i_m_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
        r_idx      <= n_idx;
        r_scan     <= n_scan;
        r_cur      <= n_cur;
        r_best     <= n_best;
        r_best_idx <= n_best_idx;
        r_val      <= n_val;
        r_pri      <= n_pri;
        r_status   <= n_status;
        r_ov       <= n_ov;
        r_op       <= n_op;
    end

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_idx      = r_idx;
        n_scan     = r_scan;
        n_cur      = r_cur;
        n_best     = r_best;
        n_best_idx = r_best_idx;
        n_val      = r_val;
        n_pri      = r_pri;
        n_status   = r_status;
        n_ov       = r_ov;
        n_op       = r_op;
        ram_we     = 1'b0;
        ram_waddr  = r_idx;
        ram_wdata  = r_cur;
        ram_raddr  = '0;
        cmp_a      = rd.pri;
        cmp_b      = r_pri;
        dec_e      = r_cur;
        dec_i      = r_idx;

        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_val    = i_s_tdata[33:2];
                    n_pri    = i_s_tdata[65:34];
                    n_status = ST_OK;
                    n_ov     = '0;
                    n_op     = '0;
                    n_state  = S_FIN_RD;
                    unique case (t_action'(i_s_tdata[1:0]))
                        ACT_INSERT: begin
                            if (r_count >= CNT_W'(CAPACITY)) begin
                                n_status = ST_FULL;
                            end else begin
                                n_idx   = r_count[IDX_W-1:0];
                                n_cur   = {i_s_tdata[65:34], i_s_tdata[33:2]};
                                n_count = r_count + CNT_W'(1);
                                n_state = S_UP_RD;
                            end
                        end
                        ACT_EXTRACT: begin
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                            end else begin
                                n_state = S_EX_ROOT;
                            end
                        end
                        ACT_MODIFY: begin
                            n_scan   = '0;
                            n_status = ST_MISSING;
                            n_state  = S_SC_RD;
                        end
                        default: begin
                            n_state = S_FIN_RD;
                        end
                    endcase
                end
            end
            S_EX_ROOT: begin
                n_ov      = rd.val;
                n_op      = rd.pri;
                ram_raddr = IDX_W'(r_count - CNT_W'(1));
                n_state   = S_EX_LAST;
            end
            S_EX_LAST: begin
                n_cur   = rd;
                n_count = r_count - CNT_W'(1);
                n_idx   = '0;
                n_state = S_DN_RDL;
            end
            S_SC_RD: begin
                if (r_scan >= r_count) begin
                    n_state = S_FIN_RD;
                end else begin
                    ram_raddr = r_scan[IDX_W-1:0];
                    n_state   = S_SC_CHK;
                end
            end
            S_SC_CHK: begin
                // a = old priority, b = new priority
                if (cmp.val_eq) begin
                    n_status = ST_OK;
                    n_cur    = {r_pri, rd.val};
                    n_idx    = r_scan[IDX_W-1:0];
                    if (cmp.lt) begin
                        n_state = S_UP_RD;
                    end else if (cmp.pri_eq) begin
                        n_state = S_FIN_RD;
                    end else begin
                        n_state = S_DN_RDL;
                    end
                end else begin
                    n_scan  = r_scan + CNT_W'(1);
                    n_state = S_SC_RD;
                end
            end
            S_UP_RD: begin
                if (r_idx == '0) begin
                    ram_we  = 1'b1;
                    n_state = S_FIN_RD;
                end else begin
                    ram_raddr = parent;
                    n_state   = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                cmp_a  = rd.pri;
                cmp_b  = r_cur.pri;
                ram_we = 1'b1;
                if (cmp.lt) begin
                    // parent moves down into the hole
                    ram_wdata = rd;
                    n_idx     = parent;
                    n_state   = S_UP_RD;
                end else begin
                    n_state = S_FIN_RD;
                end
            end
            S_DN_RDL: begin
                if (child_l >= count_x) begin
                    ram_we  = 1'b1;
                    n_state = S_FIN_RD;
                end else begin
                    ram_raddr = child_l[IDX_W-1:0];
                    n_state   = S_DN_RDR;
                end
            end
            S_DN_RDR: begin
                cmp_a = r_cur.pri;
                cmp_b = rd.pri;
                if (cmp.lt) begin
                    n_best     = rd;
                    n_best_idx = child_l[IDX_W-1:0];
                end else begin
                    n_best     = r_cur;
                    n_best_idx = r_idx;
                end
                if (child_r < count_x) begin
                    ram_raddr = child_r[IDX_W-1:0];
                    n_state   = S_DN_CMP;
                end else begin
                    dec_e   = n_best;
                    dec_i   = n_best_idx;
                    n_state = S_DN_RDL;
                end
            end
            S_DN_CMP: begin
                cmp_a = r_best.pri;
                cmp_b = rd.pri;
                if (cmp.lt) begin
                    dec_e = rd;
                    dec_i = child_r[IDX_W-1:0];
                end else begin
                    dec_e = r_best;
                    dec_i = r_best_idx;
                end
                n_state = S_DN_RDL;
            end
            S_FIN_RD: begin
                n_state = S_FIN_WT;
            end
            S_FIN_WT: begin
                if (load_out) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // sink decision: larger child fills the hole, or the moving entry settles
        if ((r_state == S_DN_CMP) ||
            ((r_state == S_DN_RDR) && !(child_r < count_x))) begin
            ram_we = 1'b1;
            if (dec_i == r_idx) begin
                ram_wdata = r_cur;
                n_state   = S_FIN_RD;
            end else begin
                ram_wdata = dec_e;
                n_idx     = dec_i;
            end
        end
    end

    assign top_e = (r_count != '0) ? rd : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (load_out) begin
            r_m_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_valid <= 1'b0;
        end
        if (load_out) begin
            r_m_data <= {6'd0, top_e.pri, top_e.val, (r_count != '0),
                         7'(r_count), r_op, r_ov, r_status};
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (o_m_tdata[1:0] == ST_FULL)) |->
        (o_m_tdata[72:66] == 7'(CAPACITY)))
        else $error("full status with room left");

    a_empty_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (o_m_tdata[1:0] == ST_EMPTY)) |->
        (!o_m_tdata[73] && (o_m_tdata[72:66] == '0)))
        else $error("empty status with entries held");

    a_top_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[73] == (o_m_tdata[72:66] != '0)))
        else $error("top valid disagrees with count");

endmodule
